/* design/wvc_pkg.sv */
// Shared constants for the weighted vote label combiner.
package wvc_pkg;

	localparam int NUM_VOTERS      = 4;
	localparam int VOTE_HALF       = NUM_VOTERS / 2;
	localparam int LABEL_W         = 5;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_IDX_W       = $clog2(NUM_VOTERS);
	localparam int MAX_LABEL_DEF   = 15;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int WEIGHT_RESET    = 256;

	// Register index of weight_0; weight_k sits at REG_WEIGHT_BASE + k.
	localparam int REG_WEIGHT_BASE = 0;

	localparam logic [LABEL_W-1:0] LABEL_NEG = '1;
	localparam logic [LABEL_W-1:0] LABEL_ONE = LABEL_W'(1);

endpackage

/* design/wvc_argmax.sv */
// Two-stage selection of the winning class from the per-voter class totals.
module wvc_argmax #(
	parameter int MAX_LABEL   = wvc_pkg::MAX_LABEL_DEF,
	parameter int WEIGHT_BITS = wvc_pkg::WEIGHT_BITS_DEF,
	localparam int SLOT_W     = $clog2(MAX_LABEL + 1),
	localparam int SUM_W      = WEIGHT_BITS + $clog2(wvc_pkg::NUM_VOTERS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [SUM_W-1:0]             tot [wvc_pkg::NUM_VOTERS],
	input  logic [SLOT_W-1:0]            slot [wvc_pkg::NUM_VOTERS],
	input  logic                         any_neg,
	output logic                         vld_out,
	output logic [wvc_pkg::LABEL_W-1:0]  winner
);
	import wvc_pkg::*;

	logic [SUM_W-1:0]    half_t_d [2];
	logic [SLOT_W-1:0]   half_s_d [2];
	logic [SUM_W-1:0]    half_t_s4 [2];
	logic [SLOT_W-1:0]   half_s_s4 [2];
	logic                neg_s4;
	logic                vld_s4;
	logic [SUM_W-1:0]    fin_t;
	logic [SLOT_W-1:0]   fin_s;
	logic [LABEL_W-1:0]  winner_d;
	logic [LABEL_W-1:0]  winner_s5;
	logic                vld_s5;

	// A candidate wins on a larger total, or on an equal total with a lower slot.
	// Slot zero is class -1, so it comes first in the tie order.
	always_comb begin
		half_t_d[0] = tot[0];
		half_s_d[0] = slot[0];
		for (int j = 1; j < VOTE_HALF; j++) begin
			if (tot[j] > half_t_d[0] || (tot[j] == half_t_d[0] && slot[j] < half_s_d[0])) begin
				half_t_d[0] = tot[j];
				half_s_d[0] = slot[j];
			end
		end
		half_t_d[1] = tot[VOTE_HALF];
		half_s_d[1] = slot[VOTE_HALF];
		for (int j = VOTE_HALF + 1; j < NUM_VOTERS; j++) begin
			if (tot[j] > half_t_d[1] || (tot[j] == half_t_d[1] && slot[j] < half_s_d[1])) begin
				half_t_d[1] = tot[j];
				half_s_d[1] = slot[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_t_s4 <= half_t_d;
			half_s_s4 <= half_s_d;
			neg_s4    <= any_neg;
		end
	end

	always_comb begin
		fin_t = half_t_s4[0];
		fin_s = half_s_s4[0];
		if (half_t_s4[1] > fin_t || (half_t_s4[1] == fin_t && half_s_s4[1] < fin_s)) begin
			fin_t = half_t_s4[1];
			fin_s = half_s_s4[1];
		end
		if (fin_t == '0) begin
			winner_d = neg_s4 ? LABEL_NEG : LABEL_ONE;
		end else if (fin_s == '0) begin
			winner_d = LABEL_NEG;
		end else begin
			winner_d = LABEL_W'(fin_s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			winner_s5 <= winner_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_in;
			vld_s5 <= vld_s4;
		end
	end

	assign vld_out = vld_s5;
	assign winner  = winner_s5;

endmodule

/* design/weighted_vote_label_combiner_unit.sv */
// Top level of the weighted majority vote label combiner pipeline.
//
// Each request on the input channel (in_valid / in_stall) carries one sample's
// labels from four classifiers. Every voter adds its weight register to the
// class it named; the result request on the output channel (out_valid /
// out_stall) gives the class with the greatest positive total, ties to the
// lowest class with -1 first. With no positive total the result is -1 if any
// voter said -1, and 1 otherwise.
// Weights are unsigned Q8.8, written via cfg_we, cfg_index and cfg_data only
// while no request is in flight; the user must ensure this, the block does not.
// The pipeline has five register stages: decode, two-part tally, class totals,
// half selection and final selection, which is the output register. A request
// passes through them in that order, and its result is offered from the output
// register. One request is taken every cycle unless a waiting result is stalled,
// because all stages advance together; the per-stage adder and comparator
// depth sets only the clock period.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is dropped or repeated.
// Reset clears every valid bit and returns all weights to 1.0 (256).
module weighted_vote_label_combiner_unit #(
	parameter int MAX_LABEL   = wvc_pkg::MAX_LABEL_DEF,
	parameter int WEIGHT_BITS = wvc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wvc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wvc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wvc_pkg::LABEL_W-1:0]  label_0,
	input  logic signed [wvc_pkg::LABEL_W-1:0]  label_1,
	input  logic signed [wvc_pkg::LABEL_W-1:0]  label_2,
	input  logic signed [wvc_pkg::LABEL_W-1:0]  label_3,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wvc_pkg::LABEL_W-1:0]  winner_label
);
	import wvc_pkg::*;

	localparam int SLOT_W = $clog2(MAX_LABEL + 1);
	localparam int SUM_W  = WEIGHT_BITS + $clog2(NUM_VOTERS);

	logic [WEIGHT_BITS-1:0] weight_q [NUM_VOTERS];

	logic [LABEL_W-1:0]     lab [NUM_VOTERS];
	logic [LABEL_W-2:0]     lab_mag [NUM_VOTERS];
	logic                   is_neg [NUM_VOTERS];
	logic                   is_cls [NUM_VOTERS];
	logic [SLOT_W-1:0]      slot_d [NUM_VOTERS];
	logic [WEIGHT_BITS-1:0] wv_d [NUM_VOTERS];
	logic                   neg_d;

	logic                   en;
	logic                   vld_s1, vld_s2, vld_s3;
	logic                   neg_s1, neg_s2, neg_s3;
	logic [SLOT_W-1:0]      slot_s1 [NUM_VOTERS];
	logic [SLOT_W-1:0]      slot_s2 [NUM_VOTERS];
	logic [SLOT_W-1:0]      slot_s3 [NUM_VOTERS];
	logic [WEIGHT_BITS-1:0] wv_s1 [NUM_VOTERS];
	logic [SUM_W-1:0]       lo_d [NUM_VOTERS];
	logic [SUM_W-1:0]       hi_d [NUM_VOTERS];
	logic [SUM_W-1:0]       lo_s2 [NUM_VOTERS];
	logic [SUM_W-1:0]       hi_s2 [NUM_VOTERS];
	logic [SUM_W-1:0]       tot_s3 [NUM_VOTERS];
	logic                   res_vld;
	logic [LABEL_W-1:0]     res_label;

	// Weight registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_VOTERS; k++) begin
				weight_q[k] <= WEIGHT_BITS'(WEIGHT_RESET);
			end
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_VOTERS; k++) begin
				if (cfg_index == CFG_IDX_W'(REG_WEIGHT_BASE + k)) begin
					weight_q[k] <= WEIGHT_BITS'(cfg_data);
				end
			end
		end
	end

	// The whole pipeline moves together unless a finished result is held.
	assign en       = !(res_vld && out_stall);
	assign in_stall = !en;

	assign lab[0] = label_0;
	assign lab[1] = label_1;
	assign lab[2] = label_2;
	assign lab[3] = label_3;

	// Stage 1: map each label to a class slot and gate its weight.
	always_comb begin
		neg_d = 1'b0;
		for (int k = 0; k < NUM_VOTERS; k++) begin
			lab_mag[k] = lab[k][LABEL_W-2:0];
			is_neg[k]  = (lab[k] == LABEL_NEG);
			is_cls[k]  = !lab[k][LABEL_W-1] && (lab_mag[k] != '0)
				&& (32'(lab_mag[k]) <= 32'(MAX_LABEL));
			slot_d[k]  = is_neg[k] ? '0 : SLOT_W'(lab_mag[k]);
			wv_d[k]    = (is_neg[k] || is_cls[k]) ? weight_q[k] : '0;
			neg_d      = neg_d | is_neg[k];
		end
	end

	// Stage 2: each voter sums the weights of all voters naming its class,
	// split over the two halves of the voter set.
	always_comb begin
		for (int k = 0; k < NUM_VOTERS; k++) begin
			lo_d[k] = '0;
			hi_d[k] = '0;
			for (int j = 0; j < VOTE_HALF; j++) begin
				if (slot_s1[j] == slot_s1[k]) begin
					lo_d[k] = lo_d[k] + SUM_W'(wv_s1[j]);
				end
			end
			for (int j = VOTE_HALF; j < NUM_VOTERS; j++) begin
				if (slot_s1[j] == slot_s1[k]) begin
					hi_d[k] = hi_d[k] + SUM_W'(wv_s1[j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= slot_d;
			wv_s1   <= wv_d;
			neg_s1  <= neg_d;
			slot_s2 <= slot_s1;
			lo_s2   <= lo_d;
			hi_s2   <= hi_d;
			neg_s2  <= neg_s1;
			slot_s3 <= slot_s2;
			neg_s3  <= neg_s2;
			for (int k = 0; k < NUM_VOTERS; k++) begin
				tot_s3[k] <= lo_s2[k] + hi_s2[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	wvc_argmax #(
		.MAX_LABEL   (MAX_LABEL),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_argmax (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s3),
		.tot     (tot_s3),
		.slot    (slot_s3),
		.any_neg (neg_s3),
		.vld_out (res_vld),
		.winner  (res_label)
	);

	assign out_valid    = res_vld;
	assign winner_label = res_label;

endmodule

/* design/wvc_checker.sv */
// Port-level checks for the weighted vote label combiner, bound to its top level.
module wvc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [wvc_pkg::LABEL_W-1:0]  winner_label
);
	import wvc_pkg::*;

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(winner_label))
		else $error("held result changed");

	// The input is only held back while a finished result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no waiting result");

	// Label zero means no vote and is never a winner.
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> winner_label != '0)
		else $error("winner label is zero");

	// The only negative winner is the class -1.
	a_neg_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !winner_label[LABEL_W-1] || winner_label == LABEL_NEG)
		else $error("winner label below -1");

endmodule

bind weighted_vote_label_combiner_unit wvc_checker u_wvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.winner_label (winner_label)
);
